[rtl/bmra_pkg.sv]
// ----------------------------------------------------------------------------
// bmra_pkg
// Shared types and constants of the bitmap run allocator.
// ----------------------------------------------------------------------------
package bmra_pkg;

  localparam int RUN_W   = 10;  // width of a requested run length
  localparam int START_W = 9;   // width of a returned start unit
  localparam int CFG_W   = 7;   // width of the map size register

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FINISH
  } bmra_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new request, restart the scan at the cursor
    logic scan;      // evaluate the byte in the read register
    logic fail;      // end the request as failed (no room or bad request), cursor back to zero
    logic mark;      // write one byte of the found run
    logic out_load;  // move the result into the output register
  } bmra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;        // zero request or cursor outside the map
    logic hit;        // the run completes in the current byte
    logic scan_end;   // the current byte is the last byte of the map
    logic mark_last;  // the byte being marked is the last byte of the run
    logic out_free;   // output register can take a result this cycle
  } bmra_status_t;

endpackage

[rtl/bmra_ctrl.sv]
// ----------------------------------------------------------------------------
// bmra_ctrl
// Sequencer of the allocator: scan, mark and result hand-off.
// ----------------------------------------------------------------------------
module bmra_ctrl
  import bmra_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  bmra_status_t status_i,
  output bmra_cmd_t    cmd_o
);

  bmra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (status_i.bad) begin
          state_d = ST_FINISH;
        end else if (status_i.hit) begin
          state_d = ST_MARK;
        end else if (status_i.scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_MARK: begin
        if (status_i.mark_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = !status_i.bad;
        cmd_o.fail = status_i.bad || (!status_i.hit && status_i.scan_end);
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/bmra_dp.sv]
// ----------------------------------------------------------------------------
// bmra_dp
// Datapath: map memory, cursor, byte scanner, run marker and output register.
// ----------------------------------------------------------------------------
module bmra_dp
  import bmra_pkg::*;
#(
  parameter int MAP_BYTES_MAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [RUN_W-1:0]   run_length_i,
  input  bmra_cmd_t          cmd_i,
  output bmra_status_t       status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_status_o,
  output logic [START_W-1:0] out_start_o
);

  localparam int BW = (MAP_BYTES_MAX > 1) ? $clog2(MAP_BYTES_MAX) : 1;
  localparam int LW = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;
  localparam int UW = BW + 3;

  // Configuration.
  logic [CFG_W-1:0] map_bytes_q;
  logic [LW-1:0]    map_ext, max_c, limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bytes_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      map_bytes_q <= cfg_wdata_i;
    end
  end

  assign map_ext = LW'(map_bytes_q);
  assign max_c   = LW'(MAP_BYTES_MAX);
  assign limit   = (map_ext > max_c) ? max_c : map_ext;

  // Request and scan state.
  logic [RUN_W-1:0] need_q, found_q, found_d;
  logic [BW-1:0]    cursor_byte_q, byte_q, mark_q;
  logic [2:0]       cursor_bit_q;
  logic             first_q;
  logic [BW-1:0]    fbyte_q, fbyte_d, lbyte_q;
  logic [2:0]       fbit_q, fbit_d, lbit_q;
  logic [7:0]       fval_q, fval_d, lval_q;
  logic             res_fail_q;

  // Map memory with one valid bit per byte row; an invalid row reads zero.
  logic [7:0]    mem [MAP_BYTES_MAX];
  logic          row_vld_q [MAP_BYTES_MAX];
  logic [BW-1:0] rd_addr;
  logic [7:0]    rd_data_q, cur_val;
  logic          rd_vld_q;
  logic [7:0]    wdata;

  assign rd_addr = cmd_i.scan ? BW'(byte_q + 1'b1) : cursor_byte_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    if (cmd_i.mark) begin
      mem[mark_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      for (int i = 0; i < MAP_BYTES_MAX; i++) row_vld_q[i] <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr];
      if (cmd_i.mark) row_vld_q[mark_q] <= 1'b1;
    end
  end

  assign cur_val = rd_vld_q ? rd_data_q : 8'h00;

  // Byte scanner: walks the eight bits of the current byte in order.
  logic [2:0]    start_bit, hit_bit;
  logic          hit;
  logic [LW-1:0] byte_nx;

  assign start_bit = first_q ? cursor_bit_q : 3'd0;
  assign byte_nx   = LW'(byte_q) + LW'(1);

  always_comb begin
    found_d = found_q;
    fbyte_d = fbyte_q;
    fbit_d  = fbit_q;
    fval_d  = fval_q;
    hit     = 1'b0;
    hit_bit = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (!hit && (3'(b) >= start_bit)) begin
        if (cur_val[b]) begin
          found_d = '0;
        end else begin
          if (found_d == '0) begin
            fbyte_d = byte_q;
            fbit_d  = 3'(b);
            fval_d  = cur_val;
          end
          found_d = found_d + RUN_W'(1);
          if (found_d == need_q) begin
            hit     = 1'b1;
            hit_bit = 3'(b);
          end
        end
      end
    end
  end

  // Marker: old value of the end bytes is kept from the scan; interior bytes
  // of a run were all clear.
  logic [2:0] lo, hi;
  logic [7:0] base, mask;

  always_comb begin
    lo   = (mark_q == fbyte_q) ? fbit_q : 3'd0;
    hi   = (mark_q == lbyte_q) ? lbit_q : 3'd7;
    base = (mark_q == fbyte_q) ? fval_q : ((mark_q == lbyte_q) ? lval_q : 8'h00);
    for (int b = 0; b < 8; b++) begin
      mask[b] = (3'(b) >= lo) && (3'(b) <= hi);
    end
    wdata = base | mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_byte_q <= '0;
      cursor_bit_q  <= '0;
      first_q       <= 1'b0;
      res_fail_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        first_q    <= 1'b1;
        res_fail_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        first_q <= 1'b0;
        if (hit) begin
          if (hit_bit == 3'd7) begin
            cursor_bit_q  <= 3'd0;
            cursor_byte_q <= (byte_nx >= limit) ? '0 : BW'(byte_nx);
          end else begin
            cursor_bit_q  <= hit_bit + 3'd1;
            cursor_byte_q <= byte_q;
          end
        end
      end
      if (cmd_i.fail) begin
        cursor_byte_q <= '0;
        cursor_bit_q  <= '0;
        res_fail_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      need_q  <= run_length_i;
      byte_q  <= cursor_byte_q;
      found_q <= '0;
    end
    if (cmd_i.scan) begin
      found_q <= found_d;
      fbyte_q <= fbyte_d;
      fbit_q  <= fbit_d;
      fval_q  <= fval_d;
      byte_q  <= BW'(byte_nx);
      if (hit) begin
        lbyte_q <= byte_q;
        lbit_q  <= hit_bit;
        lval_q  <= cur_val;
        mark_q  <= fbyte_d;
      end
    end
    if (cmd_i.mark) begin
      mark_q <= mark_q + BW'(1);
    end
  end

  // Output register.
  logic               out_valid_q;
  logic               out_status_q;
  logic [START_W-1:0] out_start_q;
  logic [UW+8:0]      first_ext;

  assign first_ext = {9'd0, fbyte_q, fbit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_fail_q;
      out_start_q  <= res_fail_q ? '0 : first_ext[START_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_start_o  = out_start_q;

  assign status_o.bad       = first_q && ((need_q == '0) || (LW'(cursor_byte_q) >= limit));
  assign status_o.hit       = hit;
  assign status_o.scan_end  = byte_nx >= limit;
  assign status_o.mark_last = mark_q == lbyte_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[rtl/bitmap_run_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_run_allocator_top
// Next-fit allocator of contiguous runs over a map of used bits.
// ----------------------------------------------------------------------------
// A request beat on the slave stream carries a run length. The block scans
// the used-bit map from its roving cursor toward the end of the map, one map
// byte per cycle, for that many consecutive clear bits. On success it sets
// those bits one byte per cycle, moves the cursor one bit past the run and
// returns the start unit with tuser low; otherwise it returns tuser high,
// start zero, and the cursor goes back to zero. A zero request always fails.
// After the accepted request beat the block scans, on success marks the run,
// and loads the result into the output register once that register is free;
// the byte-wide read port of the map memory makes scan and mark go one byte
// at a time. One request is in work at a time, and the next request beat can
// be taken in the cycle after the result is loaded. The result sits in an
// output register, so a new request is taken while a result still waits; a
// stalled master side only holds the next result back. Reset clears the map
// (per-byte valid flags), the cursor, and sets map_bytes to 64. cfg_we_i
// writes map_bytes and must only be used while idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_top
  import bmra_pkg::*;
#(
  parameter int MAP_BYTES_MAX = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: map size in bytes.
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // Request stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [9:0] run_length
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [8:0] start_unit
  output logic [0:0]       m_axis_tuser    // [0] status
);

  bmra_cmd_t          cmd;
  bmra_status_t       status;
  logic               out_status;
  logic [START_W-1:0] out_start;

  // The controller issues one command set per cycle from its state, the request valid and the datapath status.
  bmra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the map, the cursor and the output register.
  bmra_dp #(
    .MAP_BYTES_MAX (MAP_BYTES_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .run_length_i (s_axis_tdata[RUN_W-1:0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_start_o  (out_start)
  );

  // Pad the start unit to whole bytes.
  assign m_axis_tdata = {7'd0, out_start};
  assign m_axis_tuser = out_status;

endmodule

[rtl/bmra_checker.sv]
// ----------------------------------------------------------------------------
// bmra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bmra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A failed request reports start unit zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[8:0] == 9'd0)
    else $error("failed request with nonzero start unit");

  // After a request beat the block is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // A result appears only at the end of a request's work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a request in work");

endmodule

bind bitmap_run_allocator_top bmra_checker u_bmra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
